/* rtl/spc_pkg.sv */
// Shared types, constants and battery scaling functions of the stimulator panel controller.
// Used by every other file of the block but spc_if; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package spc_pkg;

   // Default width of the millisecond time base.
   localparam int SPC_TIME_WIDTH = 32;

   // Configuration port geometry: five 32-bit registers at 4-byte steps.
   localparam int SPC_ADDR_WIDTH = 5;
   localparam int SPC_DATA_WIDTH = 32;

   // Register field widths.
   localparam int DEBOUNCE_WIDTH = 10;
   localparam int PERIOD_WIDTH   = 14;
   localparam int PERCENT_WIDTH  = 7;
   localparam int SAMPLE_WIDTH   = 12;

   // Register reset values.
   localparam int DEBOUNCE_RESET   = 30;
   localparam int ADC_PERIOD_RESET = 250;
   localparam int LOW_BATT_RESET   = 20;
   localparam int LOW_BLINK_RESET  = 100;
   localparam int SLOW_BLINK_RESET = 500;

   // Register indexes of the configuration port (byte address divided by four).
   typedef enum logic [2:0] {
      REG_DEBOUNCE   = 3'd0,
      REG_ADC_PERIOD = 3'd1,
      REG_LOW_BATT   = 3'd2,
      REG_LOW_BLINK  = 3'd3,
      REG_SLOW_BLINK = 3'd4
   } spc_reg_type;

   // Battery scaling: percent = floor((sample*1650 - 4095000) / 10647), clamped to 0..100.
   // The division is a multiply by ceil(2^32 / 10647) and a shift, exact over the whole
   // range of the difference.
   localparam int SPC_SCALE_MUL    = 1650;
   localparam int SPC_SCALE_OFFSET = 4095000;
   localparam int SPC_RECIP        = 403397;
   localparam int SPC_RECIP_SHIFT  = 32;
   localparam int SPC_NUM_WIDTH    = 23;
   localparam int SPC_DIFF_WIDTH   = 22;
   localparam int SPC_PROD_WIDTH   = 41;
   localparam int SPC_QUOT_WIDTH   = SPC_PROD_WIDTH - SPC_RECIP_SHIFT;
   localparam int PERCENT_FULL     = 100;

   typedef struct packed {
      logic [DEBOUNCE_WIDTH-1:0] debounce_time;
      logic [PERIOD_WIDTH-1:0]   adc_period_ms;
      logic [PERCENT_WIDTH-1:0]  low_battery_percent;
      logic [PERIOD_WIDTH-1:0]   low_blink_ms;
      logic [PERIOD_WIDTH-1:0]   slow_blink_ms;
   } spc_cfg_type;

   // A request after the first half of the battery scaling.
   typedef struct packed {
      logic                      start_level;
      logic                      mode_level;
      logic                      adc_ok;
      logic                      below_zero;
      logic [SPC_DIFF_WIDTH-1:0] diff;
   } spc_item_type;

   typedef struct packed {
      logic                     stim_enable;
      logic                     stim_mode;
      logic                     timer_reload;
      logic                     system_led;
      logic                     stim_led;
      logic [PERCENT_WIDTH-1:0] battery_percent;
   } spc_result_type;

   // Scales the sample and removes the offset; flags samples that map below zero.
   function automatic spc_item_type spc_prescale(input logic start_level,
                                                 input logic mode_level,
                                                 input logic adc_ok,
                                                 input logic [SAMPLE_WIDTH-1:0] sample);
      logic [SPC_NUM_WIDTH-1:0] num;
      logic [SPC_NUM_WIDTH-1:0] offset;
      logic [SPC_NUM_WIDTH-1:0] delta;
      spc_item_type item;
      num    = SPC_NUM_WIDTH'(sample) * SPC_NUM_WIDTH'(SPC_SCALE_MUL);
      offset = SPC_NUM_WIDTH'(SPC_SCALE_OFFSET);
      delta  = num - offset;
      item.start_level = start_level;
      item.mode_level  = mode_level;
      item.adc_ok      = adc_ok;
      item.below_zero  = (num < offset);
      item.diff        = delta[SPC_DIFF_WIDTH-1:0];
      return item;
   endfunction

   // Divides the offset-free value by the scale divisor and clamps to full charge.
   function automatic logic [PERCENT_WIDTH-1:0] spc_percent(input spc_item_type item);
      logic [SPC_PROD_WIDTH-1:0] prod;
      logic [SPC_QUOT_WIDTH-1:0] quot;
      logic [PERCENT_WIDTH-1:0]  pct;
      prod = SPC_PROD_WIDTH'(item.diff) * SPC_PROD_WIDTH'(SPC_RECIP);
      quot = prod[SPC_PROD_WIDTH-1:SPC_RECIP_SHIFT];
      if (item.below_zero) begin
         pct = '0;
      end else if (quot > SPC_QUOT_WIDTH'(PERCENT_FULL)) begin
         pct = PERCENT_WIDTH'(PERCENT_FULL);
      end else begin
         pct = quot[PERCENT_WIDTH-1:0];
      end
      return pct;
   endfunction

endpackage

`default_nettype wire

/* rtl/spc_if.sv */
// Valid/ready channel interfaces for the requests and results of the panel controller.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface spc_req_if;
   logic        valid;
   logic        ready;
   logic        start_level;
   logic        mode_level;
   logic        adc_ok;
   logic [11:0] adc_sample;

   modport source (output valid, start_level, mode_level, adc_ok, adc_sample, input ready);
   modport sink (input valid, start_level, mode_level, adc_ok, adc_sample, output ready);
endinterface

interface spc_rsp_if;
   logic       valid;
   logic       ready;
   logic       stim_enable;
   logic       stim_mode;
   logic       timer_reload;
   logic       system_led;
   logic       stim_led;
   logic [6:0] battery_percent;

   modport source (output valid, stim_enable, stim_mode, timer_reload, system_led, stim_led,
                   battery_percent, input ready);
   modport sink (input valid, stim_enable, stim_mode, timer_reload, system_led, stim_led,
                 battery_percent, output ready);
endinterface

`default_nettype wire

/* rtl/spc_csr.sv */
// APB-style configuration registers of the panel controller.
// Depends on spc_pkg for the register layout and reset values.
`timescale 1ns / 1ps
`default_nettype none

module spc_csr
   import spc_pkg::*;
(
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       csr_psel,
   input  wire                       csr_penable,
   input  wire                       csr_pwrite,
   input  wire [SPC_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire [SPC_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [SPC_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output spc_cfg_type               cfg
);

   spc_cfg_type cfg_ff;
   spc_cfg_type cfg_in;
   spc_reg_type reg_index;
   logic        write_en;

   assign reg_index  = spc_reg_type'(csr_paddr[SPC_ADDR_WIDTH-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_DEBOUNCE: begin
               cfg_in.debounce_time = csr_pwdata[DEBOUNCE_WIDTH-1:0];
            end
            REG_ADC_PERIOD: begin
               cfg_in.adc_period_ms = csr_pwdata[PERIOD_WIDTH-1:0];
            end
            REG_LOW_BATT: begin
               cfg_in.low_battery_percent = csr_pwdata[PERCENT_WIDTH-1:0];
            end
            REG_LOW_BLINK: begin
               cfg_in.low_blink_ms = csr_pwdata[PERIOD_WIDTH-1:0];
            end
            REG_SLOW_BLINK: begin
               cfg_in.slow_blink_ms = csr_pwdata[PERIOD_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_DEBOUNCE:   csr_prdata = SPC_DATA_WIDTH'(cfg_ff.debounce_time);
         REG_ADC_PERIOD: csr_prdata = SPC_DATA_WIDTH'(cfg_ff.adc_period_ms);
         REG_LOW_BATT:   csr_prdata = SPC_DATA_WIDTH'(cfg_ff.low_battery_percent);
         REG_LOW_BLINK:  csr_prdata = SPC_DATA_WIDTH'(cfg_ff.low_blink_ms);
         REG_SLOW_BLINK: csr_prdata = SPC_DATA_WIDTH'(cfg_ff.slow_blink_ms);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time       <= DEBOUNCE_WIDTH'(DEBOUNCE_RESET);
         cfg_ff.adc_period_ms       <= PERIOD_WIDTH'(ADC_PERIOD_RESET);
         cfg_ff.low_battery_percent <= PERCENT_WIDTH'(LOW_BATT_RESET);
         cfg_ff.low_blink_ms        <= PERIOD_WIDTH'(LOW_BLINK_RESET);
         cfg_ff.slow_blink_ms       <= PERIOD_WIDTH'(SLOW_BLINK_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/spc_core.sv */
// Per-tick state of the panel controller: time base, battery percent, button debounce,
// stimulator on/off and mode, and both LED blinkers. Depends on spc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spc_core
   import spc_pkg::*;
#(
   parameter int TIME_WIDTH = SPC_TIME_WIDTH
) (
   input  wire            clock,
   input  wire            reset,
   input  wire            step,
   input  spc_item_type   item,
   input  spc_cfg_type    cfg,
   output spc_result_type result
);

   logic [TIME_WIDTH-1:0]    now_ff, now_in;
   logic [TIME_WIDTH-1:0]    last_sample_ff, last_sample_in;
   logic [TIME_WIDTH-1:0]    last_start_ff, last_start_in;
   logic [TIME_WIDTH-1:0]    last_mode_ff, last_mode_in;
   logic [TIME_WIDTH-1:0]    sys_toggle_ff, sys_toggle_in;
   logic [TIME_WIDTH-1:0]    stim_toggle_ff, stim_toggle_in;
   logic [PERCENT_WIDTH-1:0] percent_ff, percent_in;
   logic                     prev_start_ff, prev_mode_ff;
   logic                     running_ff, running_in;
   logic                     fast_ff, fast_in;
   logic                     sys_level_ff, sys_level_in;
   logic                     stim_phase_ff, stim_phase_in;
   logic                     stim_level_ff, stim_level_in;

   logic [TIME_WIDTH-1:0]    el_sample, el_start, el_mode, el_sys, el_stim;
   logic                     start_hit, mode_hit, reload;

   // All time differences wrap at the width of the time base.
   assign el_sample = now_ff - last_sample_ff;
   assign el_start  = now_ff - last_start_ff;
   assign el_mode   = now_ff - last_mode_ff;
   assign el_sys    = now_ff - sys_toggle_ff;
   assign el_stim   = now_ff - stim_toggle_ff;

   assign start_hit = !item.start_level && prev_start_ff &&
                      (el_start >= TIME_WIDTH'(cfg.debounce_time));
   assign mode_hit  = !item.mode_level && prev_mode_ff &&
                      (el_mode >= TIME_WIDTH'(cfg.debounce_time));

   assign running_in = running_ff ^ start_hit;
   assign fast_in    = fast_ff ^ mode_hit;
   assign reload     = (start_hit && running_in) || mode_hit;
   assign now_in     = now_ff + TIME_WIDTH'(1);

   always_comb begin
      last_sample_in = last_sample_ff;
      percent_in     = percent_ff;
      if (el_sample >= TIME_WIDTH'(cfg.adc_period_ms)) begin
         last_sample_in = now_ff;
         if (item.adc_ok) begin
            percent_in = spc_percent(item);
         end
      end
   end

   assign last_start_in = start_hit ? now_ff : last_start_ff;
   assign last_mode_in  = mode_hit ? now_ff : last_mode_ff;

   always_comb begin
      sys_level_in  = sys_level_ff;
      sys_toggle_in = sys_toggle_ff;
      if (percent_in < cfg.low_battery_percent) begin
         if (el_sys >= TIME_WIDTH'(cfg.low_blink_ms)) begin
            sys_level_in  = !sys_level_ff;
            sys_toggle_in = now_ff;
         end
      end else begin
         sys_level_in = 1'b1;
      end
   end

   always_comb begin
      stim_phase_in  = stim_phase_ff;
      stim_level_in  = stim_level_ff;
      stim_toggle_in = stim_toggle_ff;
      if (!running_in) begin
         stim_phase_in = 1'b0;
         stim_level_in = 1'b0;
      end else if (fast_in) begin
         stim_level_in = 1'b1;
      end else if (el_stim >= TIME_WIDTH'(cfg.slow_blink_ms)) begin
         stim_phase_in  = !stim_phase_ff;
         stim_level_in  = !stim_phase_ff;
         stim_toggle_in = now_ff;
      end
   end

   assign result.stim_enable     = running_in;
   assign result.stim_mode       = fast_in;
   assign result.timer_reload    = reload;
   assign result.system_led      = sys_level_in;
   assign result.stim_led        = stim_level_in;
   assign result.battery_percent = percent_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff         <= '0;
         last_sample_ff <= '0;
         last_start_ff  <= '0;
         last_mode_ff   <= '0;
         sys_toggle_ff  <= '0;
         stim_toggle_ff <= '0;
         percent_ff     <= PERCENT_WIDTH'(PERCENT_FULL);
         prev_start_ff  <= 1'b1;
         prev_mode_ff   <= 1'b1;
         running_ff     <= 1'b0;
         fast_ff        <= 1'b0;
         sys_level_ff   <= 1'b0;
         stim_phase_ff  <= 1'b0;
         stim_level_ff  <= 1'b0;
      end else if (step) begin
         now_ff         <= now_in;
         last_sample_ff <= last_sample_in;
         last_start_ff  <= last_start_in;
         last_mode_ff   <= last_mode_in;
         sys_toggle_ff  <= sys_toggle_in;
         stim_toggle_ff <= stim_toggle_in;
         percent_ff     <= percent_in;
         prev_start_ff  <= item.start_level;
         prev_mode_ff   <= item.mode_level;
         running_ff     <= running_in;
         fast_ff        <= fast_in;
         sys_level_ff   <= sys_level_in;
         stim_phase_ff  <= stim_phase_in;
         stim_level_ff  <= stim_level_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/stimulator_panel_controller_top.sv */
// Top level of the stimulator panel controller: request register, tick logic, result register.
// Depends on spc_pkg, spc_if, spc_csr and spc_core.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// Each request on the req channel is one millisecond tick. It carries the START and MODE
// pin levels (active low), the ADC success flag and the 12-bit battery sample. Every request
// yields exactly one result on the rsp channel with the stimulator enable and mode, the wave
// timer reload strobe, both LED levels and the battery percent.
// A request is taken into an input register, where the scaled sample is already held. Once
// the result register is free, the tick logic runs on it and the result register is loaded;
// the result is held there until it is taken.
// One request per cycle is sustained while the receiver takes every result:
// the depth of that path is set by the reciprocal multiply of the battery scaling feeding the
// threshold compare of the system LED.
// When the receiver stalls, the result register holds its result and the input register
// still takes one more request; after that req.ready drops until the result is taken.
// Synchronous reset empties both registers, sets the registers of the configuration port to
// their defaults (debounce 30 ms, ADC period 250 ms, threshold 20 %, blink half periods 100 ms
// and 500 ms), clears the time base and starts with full battery, stimulator off, 1 Hz mode.
// Configuration registers lie at byte addresses 0, 4, 8, 12 and 16 and should be written
// only while no request is in flight.

module stimulator_panel_controller_top
   import spc_pkg::*;
#(
   parameter int TIME_WIDTH = SPC_TIME_WIDTH
) (
   input  wire                       clock,
   input  wire                       reset,
   spc_req_if.sink                   req,
   spc_rsp_if.source                 rsp,
   input  wire                       csr_psel,
   input  wire                       csr_penable,
   input  wire                       csr_pwrite,
   input  wire [SPC_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire [SPC_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [SPC_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   spc_cfg_type    cfg;
   spc_item_type   item_ff, item_in;
   spc_result_type core_result;
   spc_result_type result_ff;
   logic           item_valid_ff, item_valid_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;
   logic           advance;
   logic           accept;

   // The result register is free when it is empty or being emptied this cycle.
   assign out_free = !rsp_valid_ff || rsp.ready;
   // The held request moves through the tick logic into the result register.
   assign advance  = item_valid_ff && out_free;
   assign req.ready = !item_valid_ff || out_free;
   assign accept   = req.valid && req.ready;

   // The first half of the battery scaling is done on the way into the input register.
   assign item_in = accept ? spc_prescale(req.start_level, req.mode_level, req.adc_ok,
                                          req.adc_sample)
                           : item_ff;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (accept) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   spc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   spc_core #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset; their valid flags guard them.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (advance) begin
         result_ff <= core_result;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.stim_enable     = result_ff.stim_enable;
   assign rsp.stim_mode       = result_ff.stim_mode;
   assign rsp.timer_reload    = result_ff.timer_reload;
   assign rsp.system_led      = result_ff.system_led;
   assign rsp.stim_led        = result_ff.stim_led;
   assign rsp.battery_percent = result_ff.battery_percent;

endmodule

`default_nettype wire

/* tb/panel_check_pkg.sv */
// Tick-by-tick tracker of the stimulator panel controller: it predicts every panel result.
// It also compares the results that come back. Depends on spc_pkg.
`timescale 1ns / 1ps

package panel_check_pkg;
   import spc_pkg::*;

   // Indexes from REG_UNUSED up hold nothing.
   localparam int REG_UNUSED = int'(REG_SLOW_BLINK) + 1;

   localparam int unsigned BATT_GAIN    = 1650;
   localparam int unsigned BATT_OFFSET  = 4095000;
   localparam int unsigned BATT_DIVISOR = 10647;
   localparam int unsigned FULL_CHARGE  = 100;

   typedef logic [SPC_TIME_WIDTH-1:0] ms_count_type;

   class panel_tracker;
      spc_cfg_type cfg;
      ms_count_type now, last_sample, last_start, last_mode, sys_toggle, stim_toggle;
      logic [PERCENT_WIDTH-1:0] percent;
      logic prev_start, prev_mode, running, fast, sys_led, stim_phase, stim_led;
      spc_result_type panel_due[$];
      int unsigned faults;

      function new();
         cfg.debounce_time       = DEBOUNCE_WIDTH'(DEBOUNCE_RESET);
         cfg.adc_period_ms       = PERIOD_WIDTH'(ADC_PERIOD_RESET);
         cfg.low_battery_percent = PERCENT_WIDTH'(LOW_BATT_RESET);
         cfg.low_blink_ms        = PERIOD_WIDTH'(LOW_BLINK_RESET);
         cfg.slow_blink_ms       = PERIOD_WIDTH'(SLOW_BLINK_RESET);
         now         = '0;
         last_sample = '0;
         last_start  = '0;
         last_mode   = '0;
         sys_toggle  = '0;
         stim_toggle = '0;
         percent     = PERCENT_WIDTH'(FULL_CHARGE);
         prev_start  = 1'b1;
         prev_mode   = 1'b1;
         running     = 1'b0;
         fast        = 1'b0;
         sys_led     = 1'b0;
         stim_phase  = 1'b0;
         stim_led    = 1'b0;
         faults      = 0;
      endfunction

      // A write keeps only the bits of the register's width; other indexes are dropped.
      function void set_reg(int idx, logic [SPC_DATA_WIDTH-1:0] value);
         case (idx)
            REG_DEBOUNCE:   cfg.debounce_time       = value[DEBOUNCE_WIDTH-1:0];
            REG_ADC_PERIOD: cfg.adc_period_ms       = value[PERIOD_WIDTH-1:0];
            REG_LOW_BATT:   cfg.low_battery_percent = value[PERCENT_WIDTH-1:0];
            REG_LOW_BLINK:  cfg.low_blink_ms        = value[PERIOD_WIDTH-1:0];
            REG_SLOW_BLINK: cfg.slow_blink_ms       = value[PERIOD_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function ms_count_type since(ms_count_type mark);
         return now - mark;
      endfunction

      function logic [PERCENT_WIDTH-1:0] percent_of(logic [SAMPLE_WIDTH-1:0] sample);
         int unsigned num;
         int unsigned quot;
         num = sample * BATT_GAIN;
         if (num < BATT_OFFSET) return '0;
         quot = (num - BATT_OFFSET) / BATT_DIVISOR;
         if (quot > FULL_CHARGE) quot = FULL_CHARGE;
         return PERCENT_WIDTH'(quot);
      endfunction

      function bit press_seen(logic level, logic prev, ms_count_type last);
         return level == 1'b0 && prev == 1'b1 &&
                since(last) >= ms_count_type'(cfg.debounce_time);
      endfunction

      // Advances the panel by one millisecond tick and queues the result it must show.
      function void take_tick(logic start_level, logic mode_level, logic adc_ok,
                              logic [SAMPLE_WIDTH-1:0] sample);
         spc_result_type want;
         logic reload;
         bit start_hit;
         bit mode_hit;
         reload = 1'b0;
         if (since(last_sample) >= ms_count_type'(cfg.adc_period_ms)) begin
            if (adc_ok) percent = percent_of(sample);
            last_sample = now;
         end
         start_hit  = press_seen(start_level, prev_start, last_start);
         prev_start = start_level;
         if (start_hit) begin
            last_start = now;
            running    = ~running;
            if (running) reload = 1'b1;
         end
         mode_hit  = press_seen(mode_level, prev_mode, last_mode);
         prev_mode = mode_level;
         if (mode_hit) begin
            last_mode = now;
            fast      = ~fast;
            reload    = 1'b1;
         end
         if (percent < cfg.low_battery_percent) begin
            if (since(sys_toggle) >= ms_count_type'(cfg.low_blink_ms)) begin
               sys_led    = ~sys_led;
               sys_toggle = now;
            end
         end else begin
            sys_led = 1'b1;
         end
         if (!running) begin
            stim_phase = 1'b0;
            stim_led   = 1'b0;
         end else if (fast) begin
            stim_led = 1'b1;
         end else if (since(stim_toggle) >= ms_count_type'(cfg.slow_blink_ms)) begin
            stim_phase  = ~stim_phase;
            stim_led    = stim_phase;
            stim_toggle = now;
         end
         want.stim_enable     = running;
         want.stim_mode       = fast;
         want.timer_reload    = reload;
         want.system_led      = sys_led;
         want.stim_led        = stim_led;
         want.battery_percent = percent;
         panel_due.push_back(want);
         now = now + 1'b1;
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            faults++;
         end
      endfunction

      function void match_panel(spc_result_type got);
         spc_result_type want;
         if (panel_due.size() == 0) begin
            $display("%0t: result with nothing expected, got %p", $time, got);
            faults++;
            return;
         end
         want = panel_due.pop_front();
         compare_field("stim_enable", 32'(want.stim_enable), 32'(got.stim_enable));
         compare_field("stim_mode", 32'(want.stim_mode), 32'(got.stim_mode));
         compare_field("timer_reload", 32'(want.timer_reload), 32'(got.timer_reload));
         compare_field("system_led", 32'(want.system_led), 32'(got.system_led));
         compare_field("stim_led", 32'(want.stim_led), 32'(got.stim_led));
         compare_field("battery_percent", 32'(want.battery_percent),
                       32'(got.battery_percent));
      endfunction
   endclass

endpackage

/* tb/tb.sv */
// Top-level testbench of the stimulator panel controller: clock, reset, request and result
// drivers, configuration writes and the end-of-run verdict. Depends on spc_pkg, spc_if,
// panel_check_pkg and the RTL of stimulator_panel_controller_top.
`timescale 1ns / 1ps

module tb;
   import spc_pkg::*;
   import panel_check_pkg::*;

   // Far above the slowest correct run: about 1600 requests, each waiting out at most the
   // longest sender gap and the longest result stall, plus the register writes.
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 260;
   localparam int REG_STRIDE   = 4;
   localparam int SETTLE_TICKS = 4;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [SPC_ADDR_WIDTH-1:0] csr_paddr;
   logic [SPC_DATA_WIDTH-1:0] csr_pwdata;
   logic [SPC_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   // While quiet is set, the sender leaves no gap and the receiver starts no new stall.
   bit quiet;
   int unsigned cycle_count;
   panel_tracker tracker = new();

   spc_req_if req ();
   spc_rsp_if rsp ();

   stimulator_panel_controller_top dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Length of one idle stretch: mostly short, now and then a long one.
   function automatic int idle_span();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 12);
      return $urandom_range(25, 80);
   endfunction

   // A released button goes down now and then; a pressed one is held for a few ticks.
   function automatic logic next_level(logic level);
      if (level) return ($urandom_range(0, 7) == 0) ? 1'b0 : 1'b1;
      return ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
   endfunction

   // Battery samples cluster in the span that maps onto 0..100 percent, with the edges of
   // that span and the whole 12-bit range mixed in.
   function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return SAMPLE_WIDTH'($urandom_range(2400, 3200));
      if (pick < 85) return SAMPLE_WIDTH'($urandom_range(0, 4095));
      case ($urandom_range(0, 5))
         0: return SAMPLE_WIDTH'(0);
         1: return SAMPLE_WIDTH'(4095);
         2: return SAMPLE_WIDTH'(2481);
         3: return SAMPLE_WIDTH'(2482);
         4: return SAMPLE_WIDTH'(3127);
         default: return SAMPLE_WIDTH'(3128);
      endcase
   endfunction

   // Offers one tick request after an optional gap and returns at the falling edge after it
   // was taken. valid stays high so that a following request can go out back to back.
   task automatic send_tick(logic start_level, logic mode_level, logic adc_ok,
                            logic [SAMPLE_WIDTH-1:0] sample);
      int gap;
      gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_span();
      if (gap > 0) begin
         req.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid       = 1'b1;
      req.start_level = start_level;
      req.mode_level  = mode_level;
      req.adc_ok      = adc_ok;
      req.adc_sample  = sample;
      do @(posedge clock); while (req.ready !== 1'b1);
      tracker.take_tick(start_level, mode_level, adc_ok, sample);
      @(negedge clock);
   endtask

   // One APB write: a setup phase, then an access phase that ends when pready is high.
   task automatic csr_write(int idx, logic [SPC_DATA_WIDTH-1:0] value);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = SPC_ADDR_WIDTH'(idx * REG_STRIDE);
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      tracker.set_reg(idx, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Stops sending and waits until every queued result has come back. Each request yields
   // exactly one result, so an empty queue means the block is idle; the pipeline is then left
   // to settle before the registers change.
   task automatic drain();
      req.valid = 1'b0;
      while (tracker.panel_due.size() != 0) @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic write_all(logic [SPC_DATA_WIDTH-1:0] debounce, logic [SPC_DATA_WIDTH-1:0] adc,
                            logic [SPC_DATA_WIDTH-1:0] low_batt,
                            logic [SPC_DATA_WIDTH-1:0] low_blink,
                            logic [SPC_DATA_WIDTH-1:0] slow_blink);
      csr_write(REG_DEBOUNCE, debounce);
      csr_write(REG_ADC_PERIOD, adc);
      csr_write(REG_LOW_BATT, low_batt);
      csr_write(REG_LOW_BLINK, low_blink);
      csr_write(REG_SLOW_BLINK, slow_blink);
      // An index past the last register must leave everything as it was.
      csr_write(REG_UNUSED + $urandom_range(0, 2), $urandom());
   endtask

   // Register settings of each random phase. The first phase takes every period and the
   // debounce time to zero with a threshold above full charge, so every condition fires on
   // every tick and the system LED always blinks. The second sets 1000 ms debounce, 10000 ms
   // periods and a threshold of 100. One phase writes raw 32-bit words to check that the upper
   // bits are dropped; the rest use short times so that presses, samples and blinks come often.
   task automatic setup_phase(int phase);
      case (phase)
         0: write_all(0, 0, 127, 0, 0);
         1: write_all(1000, 10000, 100, 10000, 10000);
         4: write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
         default: write_all($urandom_range(0, 40), $urandom_range(1, 30),
                            $urandom_range(0, 100), $urandom_range(1, 20),
                            $urandom_range(1, 20));
      endcase
   endtask

   // The receiver alternates between runs of ready and stalls of random length.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            rsp.ready = 1'b1;
            hold_left = $urandom_range(0, 12);
         end else begin
            rsp.ready = 1'b0;
            hold_left = idle_span();
         end
      end
   end

   // Every result taken at a rising edge is checked against the oldest prediction.
   initial begin
      spc_result_type seen;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            seen.stim_enable     = rsp.stim_enable;
            seen.stim_mode       = rsp.stim_mode;
            seen.timer_reload    = rsp.timer_reload;
            seen.system_led      = rsp.system_led;
            seen.stim_led        = rsp.stim_led;
            seen.battery_percent = rsp.battery_percent;
            tracker.match_panel(seen);
         end
      end
   end

   // A hung handshake ends the run as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL stimulator_panel_controller_top");
      $finish;
   end

   initial begin
      logic start_pin;
      logic mode_pin;
      logic adc_ok;
      quiet           = 1'b0;
      reset           = 1'b1;
      req.valid       = 1'b0;
      req.start_level = 1'b1;
      req.mode_level  = 1'b1;
      req.adc_ok      = 1'b0;
      req.adc_sample  = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // With the reset settings no sample is due before 250 ms, and presses in the first
      // 30 ms fall inside the debounce time measured from the reset time stamps.
      send_tick(1'b1, 1'b1, 1'b1, 12'd4095);
      send_tick(1'b0, 1'b1, 1'b1, 12'd4095);
      send_tick(1'b1, 1'b0, 1'b1, 12'd0);
      send_tick(1'b1, 1'b1, 1'b1, 12'd0);
      drain();

      // Sample every tick, short debounce and blink times, threshold in the middle.
      write_all(2, 1, 50, 2, 2);
      // Both ends of the sample range, the edge of the offset and where the percent reaches 100.
      send_tick(1'b1, 1'b1, 1'b1, 12'd0);
      send_tick(1'b1, 1'b1, 1'b1, 12'd4095);
      send_tick(1'b1, 1'b1, 1'b1, 12'd2481);
      send_tick(1'b1, 1'b1, 1'b1, 12'd2482);
      send_tick(1'b1, 1'b1, 1'b1, 12'd3127);
      send_tick(1'b1, 1'b1, 1'b1, 12'd3128);
      // A failed conversion keeps the old percent.
      send_tick(1'b1, 1'b1, 1'b0, 12'hFFF);
      // START turns the stimulator on, then MODE goes to 3 kHz and back to 1 Hz, where the
      // LED keeps its lit level until the next blink toggle.
      send_tick(1'b0, 1'b1, 1'b1, 12'd2800);
      send_tick(1'b1, 1'b0, 1'b1, 12'd2800);
      send_tick(1'b1, 1'b1, 1'b1, 12'd2700);
      send_tick(1'b1, 1'b0, 1'b1, 12'd2600);
      send_tick(1'b1, 1'b1, 1'b1, 12'd2600);
      // START turns it off without a reload; MODE while off still asks for one.
      send_tick(1'b0, 1'b1, 1'b1, 12'd2500);
      send_tick(1'b1, 1'b0, 1'b1, 12'd2500);
      drain();

      start_pin = 1'b1;
      mode_pin  = 1'b1;
      for (int phase = 0; phase < PHASES; phase++) begin
         setup_phase(phase);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            quiet = ((k / 64) % 4 == 3);
            // Mostly clean presses and releases; now and then contact bounce.
            if ($urandom_range(0, 9) == 0) begin
               start_pin = 1'($urandom_range(0, 1));
               mode_pin  = 1'($urandom_range(0, 1));
            end else begin
               start_pin = next_level(start_pin);
               mode_pin  = next_level(mode_pin);
            end
            adc_ok = ($urandom_range(0, 99) < 85);
            send_tick(start_pin, mode_pin, adc_ok, pick_sample());
         end
         quiet = 1'b0;
         drain();
      end

      repeat (10) @(posedge clock);
      if (tracker.faults == 0) begin
         $display("PASS stimulator_panel_controller_top");
      end else begin
         $display("FAIL stimulator_panel_controller_top");
      end
      $finish;
   end

endmodule
